/* rtl/mrwt_pkg.sv */
// Miller-Rabin witness test: shared types and constants.
// Used by mrwt_modmul and miller_rabin_witness_test_unit; no dependencies.
`default_nettype none

package mrwt_pkg;

  // Result item: one verdict bit in a byte-wide tdata.
  localparam int unsigned OUT_TDATA_W = 8;

  // Sequencer to modular multiplier.
  typedef struct packed {
    logic start;
  } mm_req_t;

  // Modular multiplier back to sequencer.
  typedef struct packed {
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

/* rtl/miller_rabin_witness_test_unit.sv */
// Miller-Rabin witness test, one round: top level with the sequencer and output register.
// Depends on mrwt_pkg and mrwt_modmul.
`default_nettype none

// One item carries a candidate n and a witness base a, both NUM_WIDTH bits;
// one verdict item comes back per input item. n equal to 2 is prime, n below
// 2 or even is composite; both are flagged in out_tuser as decided without the
// base. For odd n >= 3 the base is reduced mod n, n-1 is split into d * 2^s,
// x = a^d mod n is formed right to left by square-and-multiply, and then up to
// s-1 further squarings look for n-1. All arithmetic goes through one modular
// multiplier that handles its multiplier one bit at a time, with an extra add step
// when that bit is set. An item takes about (1 + popcount(d) + bitlength(d) - 1 +
// s - 1) products, at most 122 at NUM_WIDTH = 62 (d all ones). in_tready is high
// only while the sequencer is idle; a finished verdict waits in the output
// register, and the next item is taken meanwhile.
module miller_rabin_witness_test_unit
  import mrwt_pkg::*;
#(
  parameter int NUM_WIDTH = 62
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [NUM_WIDTH-1:0] candidate, [2*NUM_WIDTH-1:NUM_WIDTH] witness_base, rest zero
  input  wire logic [((2*NUM_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [0] probably_prime, rest zero
  output logic [OUT_TDATA_W-1:0]                    out_tdata,
  // [0] decided_trivially
  output logic                                      out_tuser
);

  localparam int W  = NUM_WIDTH;
  localparam int SW = $clog2(W);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_REDUCE    = 4'd1;  // base mod n
  localparam logic [3:0] ST_SPLIT     = 4'd2;  // strip factors of two from n-1
  localparam logic [3:0] ST_POW_STEP  = 4'd3;
  localparam logic [3:0] ST_POW_MUL   = 4'd4;
  localparam logic [3:0] ST_POW_SQR   = 4'd5;
  localparam logic [3:0] ST_CHECK     = 4'd6;  // x == 1 or x == n-1
  localparam logic [3:0] ST_LOOP_STEP = 4'd7;
  localparam logic [3:0] ST_LOOP_SQR  = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  b_r, b_nxt;        // running base power
  logic [W-1:0]  acc_r, acc_nxt;    // a^d accumulator, then x
  logic [W-1:0]  e_r, e_nxt;        // remaining exponent bits
  logic [SW-1:0] left_r, left_nxt;  // squarings still allowed (s-1 at most)
  logic          pp_r, pp_nxt;
  logic          triv_r, triv_nxt;
  logic          ov_r, ov_nxt;
  logic          opp_r, opp_nxt;
  logic          otriv_r, otriv_nxt;

  logic [W-1:0]  in_n;
  logic [W-1:0]  in_a;
  logic [W-1:0]  nm1;
  logic          in_acc;

  mm_req_t       mm_req;
  mm_stat_t      mm_stat;
  logic [W-1:0]  mm_x;
  logic [W-1:0]  mm_y;
  logic [W-1:0]  mm_m;
  logic [W-1:0]  mm_p;

  assign in_n   = in_tdata[W-1:0];
  assign in_a   = in_tdata[2*W-1:W];
  assign nm1    = {n_r[W-1:1], 1'b0};  // n is odd here
  assign in_acc = in_tvalid && in_tready;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    b_nxt        = b_r;
    acc_nxt      = acc_r;
    e_nxt        = e_r;
    left_nxt     = left_r;
    pp_nxt       = pp_r;
    triv_nxt     = triv_r;
    mm_req.start = 1'b0;
    mm_x         = acc_r;
    mm_y         = b_r;
    mm_m         = n_r;

    unique case (state_r)
      ST_IDLE: begin
        mm_x = W'(1);
        mm_y = in_a;
        mm_m = in_n;
        if (in_acc) begin
          n_nxt    = in_n;
          e_nxt    = {1'b0, in_n[W-1:1]};  // (n-1)/2 for odd n
          left_nxt = '0;
          acc_nxt  = W'(1);
          if (in_n == W'(2)) begin
            pp_nxt    = 1'b1;
            triv_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_n[W-1:1] == '0 || !in_n[0]) begin
            pp_nxt    = 1'b0;
            triv_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            triv_nxt     = 1'b0;
            mm_req.start = 1'b1;  // a * 1 mod n reduces the base
            state_nxt    = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          b_nxt     = mm_p;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!e_r[0]) begin
          e_nxt    = {1'b0, e_r[W-1:1]};
          left_nxt = left_r + SW'(1);
        end else begin
          state_nxt = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        if (e_r == '0) begin
          state_nxt = ST_CHECK;
        end else if (e_r[0]) begin
          mm_req.start = 1'b1;
          state_nxt    = ST_POW_MUL;
        end else if (e_r[W-1:1] != '0) begin
          mm_x         = b_r;
          mm_req.start = 1'b1;
          state_nxt    = ST_POW_SQR;
        end else begin
          e_nxt = '0;
        end
      end
      ST_POW_MUL: begin
        if (mm_stat.done) begin
          acc_nxt   = mm_p;
          e_nxt     = {e_r[W-1:1], 1'b0};
          state_nxt = ST_POW_STEP;
        end
      end
      ST_POW_SQR: begin
        if (mm_stat.done) begin
          b_nxt     = mm_p;
          e_nxt     = {1'b0, e_r[W-1:1]};
          state_nxt = ST_POW_STEP;
        end
      end
      ST_CHECK: begin
        if (acc_r == W'(1) || acc_r == nm1) begin
          pp_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOOP_STEP;
        end
      end
      ST_LOOP_STEP: begin
        mm_y = acc_r;
        if (left_r == '0) begin
          pp_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          mm_req.start = 1'b1;
          left_nxt     = left_r - SW'(1);
          state_nxt    = ST_LOOP_SQR;
        end
      end
      ST_LOOP_SQR: begin
        if (mm_stat.done) begin
          acc_nxt = mm_p;
          if (mm_p == nm1) begin
            pp_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LOOP_STEP;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded from the sequencer once the slot is free.
  always_comb begin
    ov_nxt    = ov_r;
    opp_nxt   = opp_r;
    otriv_nxt = otriv_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if (state_r == ST_DONE && (!ov_r || out_tready)) begin
      ov_nxt    = 1'b1;
      opp_nxt   = pp_r;
      otriv_nxt = triv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    e_r     <= e_nxt;
    left_r  <= left_nxt;
    pp_r    <= pp_nxt;
    triv_r  <= triv_nxt;
    opp_r   <= opp_nxt;
    otriv_r <= otriv_nxt;
  end

  mrwt_modmul #(
    .W (W)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .op_x    (mm_x),
    .op_y    (mm_y),
    .op_m    (mm_m),
    .stat    (mm_stat),
    .product (mm_p)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, opp_r};
  assign out_tuser  = otriv_r;

endmodule

`default_nettype wire

/* rtl/mrwt_modmul.sv */
// Iterative modular multiplier, (x * y) mod m by add-and-double, MSB of y first.
// One shared add, compare and conditional subtract used once per cycle. Uses mrwt_pkg.
`default_nettype none

module mrwt_modmul
  import mrwt_pkg::*;
#(
  parameter int W = 62
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mm_req_t      req,
  input  wire logic [W-1:0] op_x,     // must be below op_m
  input  wire logic [W-1:0] op_y,
  input  wire logic [W-1:0] op_m,     // at least 3
  output mm_stat_t          stat,
  output logic [W-1:0]      product
);

  localparam int CW = $clog2(W + 1);

  localparam logic PH_DBL = 1'b0;
  localparam logic PH_ADD = 1'b1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  m_r, m_nxt;

  logic [W-1:0]  add_b;
  logic [W:0]    sum;
  logic [W:0]    diff;
  logic [W-1:0]  red;

  // Shared unit: acc + (acc or x), then subtract m once if not negative.
  always_comb begin
    add_b = (phase_r == PH_DBL) ? acc_r : x_r;
    sum   = {1'b0, acc_r} + {1'b0, add_b};
    diff  = sum - {1'b0, m_r};
    red   = diff[W] ? sum[W-1:0] : diff[W-1:0];
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_DBL;
      cnt_nxt   = CW'(W);
      acc_nxt   = '0;
      x_nxt     = op_x;
      y_nxt     = op_y;
      m_nxt     = op_m;
    end else if (busy_r) begin
      acc_nxt = red;
      if (phase_r == PH_DBL && y_r[W-1]) begin
        phase_nxt = PH_ADD;
      end else begin
        phase_nxt = PH_DBL;
        y_nxt     = {y_r[W-2:0], 1'b0};
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_DBL;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

`default_nettype wire
